// ----- sv/frb_pkg.sv -----
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types and constants for the flow resequencing buffer.
// ----------------------------------------------------------------------------
package frb_pkg;

    localparam int WINDOW = 32;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SEQ_W  = 32;
    localparam int HDL_W  = 32;
    localparam int KEY_W  = 64;
    localparam int CNT_W  = 6;
    localparam int APB_AW = 4;
    localparam int APB_DW = 64;

    localparam logic KIND_ENQ   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        RK_RELEASE = 2'd0,
        RK_GAP     = 2'd1,
        RK_DRAINED = 2'd2,
        RK_DROP    = 2'd3
    } t_res_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REL,
        ST_STAT
    } t_state;

    typedef struct packed {
        logic             kind;
        logic [SEQ_W-1:0] seq;
        logic [HDL_W-1:0] packet_handle;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [HDL_W-1:0] packet_handle_res;
        logic [KEY_W-1:0] flow_key_out;
        logic [SEQ_W-1:0] next_seq;
        logic [CNT_W-1:0] queue_count;
        logic             last;
    } t_res_word;

    typedef struct packed {
        logic [KEY_W-1:0] flow_key;
        logic [SEQ_W-1:0] start_seq;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [HDL_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

// ----- sv/flow_resequencing_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// flow_resequencing_buffer_unit
// Per-flow resequencing buffer: 32-slot circular store of packet handles.
// ----------------------------------------------------------------------------
// Input words (i_in_valid/o_in_ready) either enqueue a handle under its
// sequence number or flush. An in-window enqueue yields no result; enqueues
// may follow each other every cycle. An out-of-window enqueue yields one drop
// word in the cycle after acceptance. A flush reads the head slot from the
// handle RAM (registered read); if it is filled, the handle passes the RAM read
// register and the result register as the first release word, then one release
// per cycle while the next slot is filled and the receiver is ready, then one
// gap or drained status word with last set. The input stays not ready from
// flush acceptance until the status word is loaded. Results leave through a
// registered output (o_res_valid/i_res_ready); while the receiver stalls, the
// flush holds and no further drop word is taken. Reset (synchronous, i_rst_n
// low) clears the slot valid bits, count and head at once and the expected
// sequence to zero; no clearing pass is needed. Configuration: APB, flow key at
// 0x0, start sequence at 0x8, written by the user at idle only, not enforced.
// ----------------------------------------------------------------------------
module flow_resequencing_buffer_unit
    import frb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_res_word         o_res_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg             cfg;
    t_ram_req         ram_req;
    logic [HDL_W-1:0] ram_rdata;

    frb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    frb_handle_ram #(
        .DEPTH (WINDOW),
        .WIDTH (HDL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    frb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_word  (o_res_word),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

endmodule

// ----- sv/frb_handle_ram.sv -----
// ----------------------------------------------------------------------------
// frb_handle_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module frb_handle_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/frb_cfg.sv -----
// ----------------------------------------------------------------------------
// frb_cfg
// APB register file: flow key at 0x0, start sequence at 0x8.
// ----------------------------------------------------------------------------
module frb_cfg
    import frb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [KEY_W-1:0] r_flow_key;
    logic [SEQ_W-1:0] r_start_seq;
    logic             wr;

    // register select on address bit 3 only
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_key  <= '0;
            r_start_seq <= '0;
        end else if (wr) begin
            if (paddr[3]) begin
                r_start_seq <= pwdata[SEQ_W-1:0];
            end else begin
                r_flow_key <= pwdata[KEY_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[3]) begin
            prdata = APB_DW'(r_start_seq);
        end else begin
            prdata = APB_DW'(r_flow_key);
        end
    end

    assign pready          = 1'b1;
    assign o_cfg.flow_key  = r_flow_key;
    assign o_cfg.start_seq = r_start_seq;

endmodule

// ----- sv/frb_ctrl.sv -----
// ----------------------------------------------------------------------------
// frb_ctrl
// Slot bookkeeping, flush sequencer and output register.
// ----------------------------------------------------------------------------
module frb_ctrl
    import frb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_res_word        o_res_word,
    output t_ram_req         o_ram_req,
    input  logic [HDL_W-1:0] i_ram_rdata
);

    t_state           r_state, n_state;
    logic [WINDOW-1:0] r_valid, n_valid;
    logic [IDX_W-1:0] r_head, n_head;
    logic [SEQ_W-1:0] r_exp, n_exp;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_res_valid, n_res_valid;
    t_res_word        r_res_word, n_res_word;

    logic             out_free;
    logic             acc;
    logic             in_win;
    logic             more;
    logic             load;
    logic [SEQ_W-1:0] off;
    logic [IDX_W:0]   sum;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] head_nxt;

    assign out_free = !r_res_valid || i_res_ready;
    assign off      = i_in_word.seq - r_exp;
    assign in_win   = off < SEQ_W'(WINDOW);
    assign sum      = {1'b0, r_head} + off[IDX_W:0];
    assign idx      = (sum >= (IDX_W+1)'(WINDOW)) ? IDX_W'(sum - (IDX_W+1)'(WINDOW))
                                                   : sum[IDX_W-1:0];
    assign head_nxt = (r_head == IDX_W'(WINDOW - 1)) ? '0 : r_head + 1'b1;

    // another release follows if something stays held and the next slot is filled
    assign more = (r_count != CNT_W'(1)) && r_valid[head_nxt];

    // in-window enqueues never touch the output register
    assign o_in_ready = (r_state == ST_IDLE)
                        && (out_free || (i_in_word.kind == KIND_ENQ && in_win));
    assign acc        = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && i_in_word.kind == KIND_FLUSH) begin
                    if (r_count == '0 || !r_valid[r_head]) begin
                        n_state = ST_STAT;
                    end else begin
                        n_state = ST_REL;
                    end
                end
            end
            ST_REL: begin
                if (out_free && !more) begin
                    n_state = ST_STAT;
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_valid    = r_valid;
        n_head     = r_head;
        n_exp      = r_exp;
        n_count    = r_count;
        n_res_word = r_res_word;
        load       = 1'b0;
        o_ram_req  = '0;

        n_res_word.flow_key_out = i_cfg.flow_key;

        case (r_state)
            ST_IDLE: begin
                if (acc && i_in_word.kind == KIND_ENQ) begin
                    if (in_win) begin
                        o_ram_req.we    = 1'b1;
                        o_ram_req.waddr = idx;
                        o_ram_req.wdata = i_in_word.packet_handle;
                        n_valid[idx]    = 1'b1;
                        if (!r_valid[idx]) begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        load                         = 1'b1;
                        n_res_word.result_kind       = RK_DROP;
                        n_res_word.packet_handle_res = i_in_word.packet_handle;
                        n_res_word.next_seq          = r_exp;
                        n_res_word.queue_count       = r_count;
                        n_res_word.last              = 1'b1;
                    end
                end else if (acc && r_count != '0 && r_valid[r_head]) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_head;
                end
            end
            ST_REL: begin
                if (out_free) begin
                    load                         = 1'b1;
                    n_res_word.result_kind       = RK_RELEASE;
                    n_res_word.packet_handle_res = i_ram_rdata;
                    n_res_word.next_seq          = r_exp + 1'b1;
                    n_res_word.queue_count       = r_count - 1'b1;
                    n_res_word.last              = 1'b0;
                    n_valid[r_head]              = 1'b0;
                    n_head                       = head_nxt;
                    n_exp                        = r_exp + 1'b1;
                    n_count                      = r_count - 1'b1;
                    if (more) begin
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = head_nxt;
                    end
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    load                         = 1'b1;
                    n_res_word.packet_handle_res = '0;
                    n_res_word.last              = 1'b1;
                    n_res_word.queue_count       = r_count;
                    if (r_count == '0) begin
                        // drained: re-arm from the start sequence
                        n_res_word.result_kind = RK_DRAINED;
                        n_res_word.next_seq    = i_cfg.start_seq;
                        n_exp                  = i_cfg.start_seq;
                        n_head                 = '0;
                    end else begin
                        n_res_word.result_kind = RK_GAP;
                        n_res_word.next_seq    = r_exp;
                    end
                end
            end
            default: ;
        endcase

        if (load) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_head      <= '0;
            r_exp       <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_head      <= n_head;
            r_exp       <= n_exp;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res_word <= n_res_word;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_word  = r_res_word;

endmodule

// ----- sv/frb_checker.sv -----
// ----------------------------------------------------------------------------
// frb_checker
// Port-level checks for the resequencing buffer, bound to the top level.
// ----------------------------------------------------------------------------
module frb_checker
    import frb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_res_valid,
    input logic      i_res_ready,
    input t_res_word o_res_word
);

    // a stalled result word holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res_word))
        else $error("result word changed while stalled");

    // flush keeps the input closed on the following cycle
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_word.kind == KIND_FLUSH |=> !o_in_ready)
        else $error("input accepted straight after a flush");

    // only releases are non-final
    a_nonlast_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res_word.last |-> o_res_word.result_kind == RK_RELEASE)
        else $error("non-final word that is not a release");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res_word.queue_count <= CNT_W'(WINDOW))
        else $error("queue count beyond window");

    a_drained_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res_word.result_kind == RK_DRAINED
        |-> o_res_word.queue_count == '0 && o_res_word.packet_handle_res == '0)
        else $error("drained word with packets still held");

endmodule

bind flow_resequencing_buffer_unit frb_checker u_frb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res_word  (o_res_word)
);
